[rtl/core/ngfs_pkg.sv]
package ngfs_pkg;

   // Default sizes
   localparam int NUM_FIELDS_DEFAULT      = 15;
   localparam int MAX_FIELD_CHARS_DEFAULT = 16;
   localparam int CMD_DEPTH_DEFAULT       = 4;

   // Fixed field widths of the channels
   localparam int CHAR_W        = 8;
   localparam int FIELD_INDEX_W = 4;
   localparam int CHAR_INDEX_W  = 4;
   localparam int READ_LENGTH_W = 5;
   localparam int KIND_W        = 3;

   // Request types
   localparam logic REQ_RX_CHAR = 1'b0;
   localparam logic REQ_READ    = 1'b1;

   // Framing characters
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;

   // Sentence identifier length
   localparam int GGA_LEN = 5;

   // Command kinds handed from the front to the back
   localparam logic [KIND_W-1:0] KIND_IGNORE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DOLLAR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STAR   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DATA   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [CHAR_W-1:0]        ch;
      logic [FIELD_INDEX_W-1:0] field_index;
      logic [CHAR_INDEX_W-1:0]  char_index;
   } cmd_type;

   // Characters of the sentence identifier GPGGA
   function automatic logic [CHAR_W-1:0] gga_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h47;
         3'd1:    c = 8'h50;
         3'd2:    c = 8'h47;
         3'd3:    c = 8'h47;
         3'd4:    c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/nmea_gga_field_splitter.sv]
// NMEA GGA field splitter.
// Input channel (req_*): one transaction is either a received serial byte
// (req_type 0, req_rx_char) or a read of one stored field byte (req_type 1,
// req_field_index, req_char_index). Result channel (rsp_*): exactly one
// transaction per input transaction, in order. Character transactions
// report frame_done, frame_rejected and field_overflow; read transactions
// report read_char and read_length. Both channels move a transaction on a
// clock edge with valid high and stall low.
// Path: the command queue takes the input and hands the command to the
// execute stage, which registers the result together with its field memory
// read. Throughput: one transaction per cycle while the receiver does not
// stall, set by the execute stage that updates parser state and the field
// memory once per cycle. The command queue lets input keep flowing while a
// result waits; when the receiver stalls, the result holds and req_stall
// rises once the queue fills.
// Reset (synchronous) leaves the block hunting for '$', all stored fields
// empty but field 0, which reads as GPGGA. No clearing pass is needed.
module nmea_gga_field_splitter #(
   parameter int NUM_FIELDS      = ngfs_pkg::NUM_FIELDS_DEFAULT,
   parameter int MAX_FIELD_CHARS = ngfs_pkg::MAX_FIELD_CHARS_DEFAULT,
   parameter int CMD_DEPTH       = ngfs_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [ngfs_pkg::CHAR_W-1:0]         req_rx_char,
   input  logic [ngfs_pkg::FIELD_INDEX_W-1:0]  req_field_index,
   input  logic [ngfs_pkg::CHAR_INDEX_W-1:0]   req_char_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_frame_done,
   output logic                                rsp_frame_rejected,
   output logic                                rsp_field_overflow,
   output logic [ngfs_pkg::CHAR_W-1:0]         rsp_read_char,
   output logic [ngfs_pkg::READ_LENGTH_W-1:0]  rsp_read_length
);

   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_empty;
   ngfs_pkg::cmd_type cmd_in;
   ngfs_pkg::cmd_type cmd_head;

   ngfs_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_rx_char     (req_rx_char),
      .req_field_index (req_field_index),
      .req_char_index  (req_char_index),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in)
   );

   ngfs_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .head_cmd (cmd_head),
      .empty    (cmd_empty)
   );

   ngfs_back #(
      .NUM_FIELDS      (NUM_FIELDS),
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd_head),
      .cmd_empty          (cmd_empty),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_rejected (rsp_frame_rejected),
      .rsp_field_overflow (rsp_field_overflow),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_length    (rsp_read_length)
   );

endmodule

[rtl/core/ngfs_ram.sv]
module ngfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ngfs_front.sv]
module ngfs_front (
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [ngfs_pkg::CHAR_W-1:0]          req_rx_char,
   input  logic [ngfs_pkg::FIELD_INDEX_W-1:0]   req_field_index,
   input  logic [ngfs_pkg::CHAR_INDEX_W-1:0]    req_char_index,
   input  logic                                 cmd_full,
   output logic                                 cmd_push,
   output ngfs_pkg::cmd_type                    cmd_data
);

   // Stall only when the command queue has no room
   assign req_stall = cmd_full;
   assign cmd_push  = req_valid && !cmd_full;

   // Classify the transaction by request type and character
   always_comb begin
      cmd_data.ch          = req_rx_char;
      cmd_data.field_index = req_field_index;
      cmd_data.char_index  = req_char_index;
      if (req_type == ngfs_pkg::REQ_READ) begin
         cmd_data.kind = ngfs_pkg::KIND_READ;
      end else begin
         case (req_rx_char)
            ngfs_pkg::CH_NUL:    cmd_data.kind = ngfs_pkg::KIND_IGNORE;
            ngfs_pkg::CH_DOLLAR: cmd_data.kind = ngfs_pkg::KIND_DOLLAR;
            ngfs_pkg::CH_STAR:   cmd_data.kind = ngfs_pkg::KIND_STAR;
            ngfs_pkg::CH_COMMA:  cmd_data.kind = ngfs_pkg::KIND_COMMA;
            default:             cmd_data.kind = ngfs_pkg::KIND_DATA;
         endcase
      end
   end

endmodule

[rtl/core/ngfs_cmd_fifo.sv]
module ngfs_cmd_fifo #(
   parameter int DEPTH = ngfs_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ngfs_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output ngfs_pkg::cmd_type head_cmd,
   output logic              empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ngfs_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[head_ff];

   // Advance pointers with wrap, track occupancy
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/ngfs_back.sv]
module ngfs_back #(
   parameter int NUM_FIELDS      = ngfs_pkg::NUM_FIELDS_DEFAULT,
   parameter int MAX_FIELD_CHARS = ngfs_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ngfs_pkg::cmd_type                   cmd,
   input  logic                                cmd_empty,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_frame_done,
   output logic                                rsp_frame_rejected,
   output logic                                rsp_field_overflow,
   output logic [ngfs_pkg::CHAR_W-1:0]         rsp_read_char,
   output logic [ngfs_pkg::READ_LENGTH_W-1:0]  rsp_read_length
);

   localparam int FW     = $clog2(NUM_FIELDS);
   localparam int FNW    = $clog2(NUM_FIELDS + 1);
   localparam int CW     = $clog2(MAX_FIELD_CHARS);
   localparam int LW     = $clog2(MAX_FIELD_CHARS + 1);
   localparam int AW     = 1 + FW + CW;
   localparam int RamDepth = 2 ** AW;
   localparam int ChW    = ngfs_pkg::CHAR_W;
   localparam int RlW    = ngfs_pkg::READ_LENGTH_W;
   localparam int GgaLen = ngfs_pkg::GGA_LEN;

   // Parser state
   logic                 in_sentence_ff, in_sentence_in;
   logic [FNW-1:0]       field_number_ff, field_number_in;
   logic [LW-1:0]        gather_length_ff, gather_length_in;
   logic                 gga_match_ff, gga_match_in;
   logic [LW-1:0]        field_length_ff [NUM_FIELDS];
   logic [LW-1:0]        field_length_in [NUM_FIELDS];
   logic [NUM_FIELDS-1:0] bank_ff, bank_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_rej_ff, rsp_rej_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic [RlW-1:0]       rsp_len_ff, rsp_len_in;
   logic                 rsp_use_ram_ff, rsp_use_ram_in;
   logic [ChW-1:0]       rsp_const_ff, rsp_const_in;

   // Decode helpers
   logic                 field_live;
   logic [FW-1:0]        fn_idx;
   logic                 first_field;
   logic                 is_gga;
   logic                 rd_live;
   logic [FW-1:0]        rd_idx;
   logic                 rd_bank;
   logic [LW-1:0]        rd_len;
   logic                 rd_hit;
   logic                 take_data;

   // Field text memory
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [ChW-1:0]       ram_rd_data;

   // Take a command when the result register is free or draining
   assign cmd_pop = !cmd_empty && (!rsp_valid_ff || !rsp_stall);

   assign field_live  = field_number_ff < FNW'(NUM_FIELDS);
   assign fn_idx      = field_number_ff[FW-1:0];
   assign first_field = field_number_ff == '0;
   assign is_gga      = (gather_length_ff == LW'(GgaLen)) && gga_match_ff;
   assign rd_live     = int'(cmd.field_index) < NUM_FIELDS;
   assign rd_idx      = FW'(cmd.field_index);
   assign rd_bank     = rd_live ? bank_ff[rd_idx] : 1'b0;
   assign rd_len      = rd_live ? field_length_ff[rd_idx] : '0;
   assign rd_hit      = rd_live && (int'(cmd.char_index) < int'(rd_len));
   assign rd_addr     = {rd_bank, rd_idx, CW'(cmd.char_index)};
   assign wr_addr     = {field_live ? ~bank_ff[fn_idx] : 1'b0, fn_idx,
                         gather_length_ff[CW-1:0]};

   // Execute the command at the head of the queue
   always_comb begin
      in_sentence_in   = in_sentence_ff;
      field_number_in  = field_number_ff;
      gather_length_in = gather_length_ff;
      gga_match_in     = gga_match_ff;
      field_length_in  = field_length_ff;
      bank_in          = bank_ff;
      take_data        = 1'b0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      rsp_done_in      = 1'b0;
      rsp_rej_in       = 1'b0;
      rsp_ovf_in       = 1'b0;
      rsp_len_in       = '0;
      rsp_use_ram_in   = 1'b0;
      rsp_const_in     = '0;
      if (cmd_pop) begin
         case (cmd.kind)
            ngfs_pkg::KIND_DOLLAR: begin
               if (!in_sentence_ff) begin
                  in_sentence_in   = 1'b1;
                  field_number_in  = '0;
                  gather_length_in = '0;
                  gga_match_in     = 1'b1;
               end else begin
                  take_data = 1'b1;
               end
            end
            ngfs_pkg::KIND_DATA: begin
               take_data = in_sentence_ff;
            end
            ngfs_pkg::KIND_STAR: begin
               if (in_sentence_ff) begin
                  in_sentence_in   = 1'b0;
                  gather_length_in = '0;
                  rsp_done_in      = 1'b1;
               end
            end
            ngfs_pkg::KIND_COMMA: begin
               if (in_sentence_ff) begin
                  if (first_field && !is_gga) begin
                     in_sentence_in   = 1'b0;
                     gather_length_in = '0;
                     rsp_rej_in       = 1'b1;
                  end else begin
                     // Commit a non-empty field by flipping to its fresh bank
                     if (gather_length_ff != '0 && field_live) begin
                        field_length_in[fn_idx] = gather_length_ff;
                        bank_in[fn_idx]         = ~bank_ff[fn_idx];
                     end
                     gather_length_in = '0;
                     if (field_live) begin
                        field_number_in = field_number_ff + 1'b1;
                     end
                  end
               end
            end
            ngfs_pkg::KIND_READ: begin
               rd_en          = 1'b1;
               rsp_len_in     = RlW'(rd_len);
               rsp_use_ram_in = rd_hit && (rd_idx != '0);
               if (rd_hit && rd_idx == '0) begin
                  rsp_const_in = ngfs_pkg::gga_char(cmd.char_index[2:0]);
               end
            end
            default: begin
            end
         endcase

         // Gather one character into the shadow bank (field 0 is only matched against GPGGA), or flag overflow
         if (take_data) begin
            if (gather_length_ff < LW'(MAX_FIELD_CHARS)) begin
               gather_length_in = gather_length_ff + 1'b1;
               if (first_field) begin
                  if (gather_length_ff < LW'(GgaLen)) begin
                     gga_match_in = gga_match_ff &&
                        (cmd.ch == ngfs_pkg::gga_char(gather_length_ff[2:0]));
                  end
               end else if (field_live) begin
                  wr_en = 1'b1;
               end
            end else begin
               rsp_ovf_in = 1'b1;
            end
         end
      end

      // Hold the result while stalled, drop it once taken
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff   <= 1'b0;
         field_number_ff  <= '0;
         gather_length_ff <= '0;
         gga_match_ff     <= 1'b0;
         bank_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            field_length_ff[i] <= (i == 0) ? LW'(GgaLen) : '0;
         end
      end else begin
         in_sentence_ff   <= in_sentence_in;
         field_number_ff  <= field_number_in;
         gather_length_ff <= gather_length_in;
         gga_match_ff     <= gga_match_in;
         bank_ff          <= bank_in;
         rsp_valid_ff     <= rsp_valid_in;
         field_length_ff  <= field_length_in;
      end
   end

   // Load the result payload with each executed command
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_done_ff    <= rsp_done_in;
         rsp_rej_ff     <= rsp_rej_in;
         rsp_ovf_ff     <= rsp_ovf_in;
         rsp_len_ff     <= rsp_len_in;
         rsp_use_ram_ff <= rsp_use_ram_in;
         rsp_const_ff   <= rsp_const_in;
      end
   end

   ngfs_ram #(
      .WIDTH (ChW),
      .DEPTH (RamDepth)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_done     = rsp_done_ff;
   assign rsp_frame_rejected = rsp_rej_ff;
   assign rsp_field_overflow = rsp_ovf_ff;
   assign rsp_read_length    = rsp_len_ff;
   assign rsp_read_char      = rsp_use_ram_ff ? ram_rd_data : rsp_const_ff;

   // A stored byte only comes back on a read, never with parse flags
   a_read_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_use_ram_ff |-> !(rsp_done_ff || rsp_rej_ff || rsp_ovf_ff))
      else $error("read result carries parse flags");

   a_gather_bound: assert property (@(posedge clock) disable iff (reset)
      gather_length_ff <= LW'(MAX_FIELD_CHARS))
      else $error("gather length past buffer size");

   a_done_xor_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_rej_ff))
      else $error("sentence both done and rejected");

   a_star_closes: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd.kind == ngfs_pkg::KIND_STAR && in_sentence_ff
      |=> !in_sentence_ff && gather_length_ff == '0)
      else $error("star did not close the sentence");

   a_ram_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(ram_rd_data))
      else $error("read data changed under a stalled result");

endmodule
